// ===== hw/rtl/uvs_pkg.sv =====
package uvs_pkg;

  localparam int MAX_DIVISIONS = 256;
  localparam int CORDIC_STEPS = 16;
  localparam int DIV_STEPS = 33;

  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

  typedef enum logic [2:0] {
    CFG_RADIUS   = 3'd0,
    CFG_SECTORS  = 3'd1,
    CFG_STACKS   = 3'd2,
    CFG_CENTER_X = 3'd3,
    CFG_CENTER_Y = 3'd4,
    CFG_CENTER_Z = 3'd5
  } cfg_idx_t;

  typedef logic signed [31:0] trig_t;

  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] a;
    case (i)
      0: a = 32'd536870912;
      1: a = 32'd316933406;
      2: a = 32'd167458907;
      3: a = 32'd85004756;
      4: a = 32'd42667331;
      5: a = 32'd21354465;
      6: a = 32'd10679838;
      7: a = 32'd5340245;
      8: a = 32'd2670163;
      9: a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

// ===== hw/rtl/uvs_div.sv =====
module uvs_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [8:0]  idx,
  input  logic [9:0]  divisor,
  output logic        out_valid,
  output logic [32:0] quot
);
  import uvs_pkg::*;

  logic        v [0:DIV_STEPS-1];
  logic [9:0]  r [0:DIV_STEPS-1];
  logic [32:0] q [0:DIV_STEPS-1];
  logic [9:0]  r_next [0:DIV_STEPS-1];
  logic [32:0] q_next [0:DIV_STEPS-1];

  always_comb begin
    logic        ge;
    logic [10:0] t;
    ge = ({1'b0, idx} >= divisor);
    r_next[0] = ge ? ({1'b0, idx} - divisor) : {1'b0, idx};
    q_next[0] = {32'd0, ge};
    for (int k = 1; k < DIV_STEPS; k++) begin
      t = {r[k-1], 1'b0};
      ge = (t >= {1'b0, divisor});
      if (ge) begin
        r_next[k] = 10'(t - {1'b0, divisor});
      end else begin
        r_next[k] = t[9:0];
      end
      q_next[k] = {q[k-1][31:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_STEPS; k++) v[k] <= 1'b0;
    end else begin
      v[0] <= in_valid;
      for (int k = 1; k < DIV_STEPS; k++) v[k] <= v[k-1];
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      r[k] <= r_next[k];
      q[k] <= q_next[k];
    end
  end

  assign out_valid = v[DIV_STEPS-1];
  assign quot = q[DIV_STEPS-1];

endmodule

// ===== hw/rtl/uvs_cordic.sv =====
module uvs_cordic (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [31:0]   phase,
  input  logic [15:0]   tag_in,
  output logic          out_valid,
  output uvs_pkg::trig_t cos_out,
  output uvs_pkg::trig_t sin_out,
  output logic [15:0]   tag_out
);
  import uvs_pkg::*;

  logic               v    [0:CORDIC_STEPS];
  logic signed [32:0] x    [0:CORDIC_STEPS];
  logic signed [32:0] y    [0:CORDIC_STEPS];
  logic signed [33:0] z    [0:CORDIC_STEPS];
  logic [1:0]         quad [0:CORDIC_STEPS];
  logic [15:0]        tag  [0:CORDIC_STEPS];
  logic signed [32:0] x_next [1:CORDIC_STEPS];
  logic signed [32:0] y_next [1:CORDIC_STEPS];
  logic signed [33:0] z_next [1:CORDIC_STEPS];
  logic [1:0]         quad_in;
  logic [31:0]        resid;
  logic               v_post;
  trig_t              c_post;
  trig_t              s_post;
  logic [15:0]        tag_post;
  trig_t              c_next;
  trig_t              s_next;

  always_comb begin
    logic [31:0] shifted;
    shifted = phase + 32'h2000_0000;
    quad_in = shifted[31:30];
    resid = phase - {quad_in, 30'd0};
  end

  always_comb begin
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [33:0] da;
    for (int k = 1; k <= CORDIC_STEPS; k++) begin
      dx = y[k-1] >>> (k - 1);
      dy = x[k-1] >>> (k - 1);
      da = $signed({2'b00, atan_turn(k - 1)});
      if (z[k-1] >= 0) begin
        x_next[k] = x[k-1] - dx;
        y_next[k] = y[k-1] + dy;
        z_next[k] = z[k-1] - da;
      end else begin
        x_next[k] = x[k-1] + dx;
        y_next[k] = y[k-1] - dy;
        z_next[k] = z[k-1] + da;
      end
    end
  end

  always_comb begin
    logic signed [32:0] xf;
    logic signed [32:0] yf;
    xf = x[CORDIC_STEPS];
    yf = y[CORDIC_STEPS];
    case (quad[CORDIC_STEPS])
      2'd0: begin
        c_next = xf[31:0];
        s_next = yf[31:0];
      end
      2'd1: begin
        c_next = 32'(-yf);
        s_next = xf[31:0];
      end
      2'd2: begin
        c_next = 32'(-xf);
        s_next = 32'(-yf);
      end
      default: begin
        c_next = yf[31:0];
        s_next = 32'(-xf);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= CORDIC_STEPS; k++) v[k] <= 1'b0;
      v_post <= 1'b0;
    end else begin
      v[0] <= in_valid;
      for (int k = 1; k <= CORDIC_STEPS; k++) v[k] <= v[k-1];
      v_post <= v[CORDIC_STEPS];
    end
    x[0] <= CORDIC_GAIN;
    y[0] <= 33'sd0;
    z[0] <= {{2{resid[31]}}, resid};
    quad[0] <= quad_in;
    tag[0] <= tag_in;
    for (int k = 1; k <= CORDIC_STEPS; k++) begin
      x[k] <= x_next[k];
      y[k] <= y_next[k];
      z[k] <= z_next[k];
      quad[k] <= quad[k-1];
      tag[k] <= tag[k-1];
    end
    c_post <= c_next;
    s_post <= s_next;
    tag_post <= tag[CORDIC_STEPS];
  end

  assign out_valid = v_post;
  assign cos_out = c_post;
  assign sin_out = s_post;
  assign tag_out = tag_post;

endmodule

// ===== hw/rtl/uvs_out.sv =====
module uvs_out (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  uvs_pkg::trig_t      ce,
  input  uvs_pkg::trig_t      se,
  input  uvs_pkg::trig_t      ca,
  input  uvs_pkg::trig_t      sa,
  input  logic [15:0]         tu_in,
  input  logic [15:0]         tv_in,
  input  logic [14:0]         radius,
  input  logic signed [15:0]  cx,
  input  logic signed [15:0]  cy,
  input  logic signed [15:0]  cz,
  output logic                out_valid,
  output logic signed [16:0]  pos_x,
  output logic signed [16:0]  pos_y,
  output logic signed [16:0]  pos_z,
  output logic signed [15:0]  normal_x,
  output logic signed [15:0]  normal_y,
  output logic signed [15:0]  normal_z,
  output logic [15:0]         tex_u,
  output logic [15:0]         tex_v
);
  import uvs_pkg::*;

  logic v1, v2, v3, v4;
  logic signed [63:0] px, py;
  trig_t se1;
  logic [15:0] tu1, tv1, tu2, tv2, tu3, tv3;
  logic signed [32:0] dx, dy, dz;
  logic signed [48:0] rx, ry, rz;
  logic signed [15:0] nx3, ny3, nz3;
  logic signed [63:0] pxr, pyr;

  function automatic logic signed [15:0] norm_of(input logic signed [32:0] d);
    logic signed [32:0] t;
    logic signed [16:0] n;
    t = d + 33'sd32768;
    n = t[32:16];
    if (n > 17'sd16384) begin
      return 16'sd16384;
    end else if (n < -17'sd16384) begin
      return -16'sd16384;
    end
    return n[15:0];
  endfunction

  function automatic logic signed [16:0] pos_of(input logic signed [48:0] rp,
                                                input logic signed [15:0] c);
    logic signed [48:0] t;
    logic signed [20:0] p;
    t = rp + 49'sd536870912;
    p = {{2{t[48]}}, t[48:30]} + {{5{c[15]}}, c};
    if (p > 21'sd65535) begin
      return 17'sd65535;
    end else if (p < -21'sd65536) begin
      return -17'sd65536;
    end
    return p[16:0];
  endfunction

  assign pxr = px + 64'sd536870912;
  assign pyr = py + 64'sd536870912;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
    px <= ce * ca;
    py <= ce * sa;
    se1 <= se;
    tu1 <= tu_in;
    tv1 <= tv_in;

    dx <= pxr[62:30];
    dy <= pyr[62:30];
    dz <= {se1[31], se1};
    tu2 <= tu1;
    tv2 <= tv1;

    rx <= $signed({1'b0, radius}) * dx;
    ry <= $signed({1'b0, radius}) * dy;
    rz <= $signed({1'b0, radius}) * dz;
    nx3 <= norm_of(dx);
    ny3 <= norm_of(dy);
    nz3 <= norm_of(dz);
    tu3 <= tu2;
    tv3 <= tv2;

    pos_x <= pos_of(rx, cx);
    pos_y <= pos_of(ry, cy);
    pos_z <= pos_of(rz, cz);
    normal_x <= nx3;
    normal_y <= ny3;
    normal_z <= nz3;
    tex_u <= tu3;
    tex_v <= tv3;
  end

  assign out_valid = v4;

endmodule

// ===== hw/rtl/uv_sphere_vertex_generator.sv =====
// UV-sphere vertex generator: one grid point in, one vertex out.
// The path from the accepting edge to the done strobe has 1 input stage,
// 33 divider stages (one quotient bit each), 18 CORDIC stages and 4 output stages.
// Throughput is one beat per cycle; busy is never raised and results cannot stall.
// Synchronous reset clears all valid bits and loads the default register values.
module uv_sphere_vertex_generator (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [8:0]          stack_index,
  input  logic [8:0]          sector_index,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output logic                done,
  output logic signed [16:0]  pos_x,
  output logic signed [16:0]  pos_y,
  output logic signed [16:0]  pos_z,
  output logic signed [15:0]  normal_x,
  output logic signed [15:0]  normal_y,
  output logic signed [15:0]  normal_z,
  output logic [15:0]         tex_u,
  output logic [15:0]         tex_v
);
  import uvs_pkg::*;

  logic [14:0] sphere_radius;
  logic [8:0]  sector_count;
  logic [8:0]  stack_count;
  logic signed [15:0] center_x, center_y, center_z;

  logic [8:0] sectors, stacks;
  logic [8:0] stk_clamped, sec_clamped;
  logic       v_in;
  logic [8:0] stk_in, sec_in;

  logic        sec_dv, stk_dv;
  logic [32:0] sec_quot, stk_quot;
  logic [31:0] ph_sector, ph_stack;
  logic [33:0] tv_sum, tu_sum;
  logic [15:0] tv_div, tu_div;

  logic        ca_v, ce_v;
  trig_t       ca, sa, ce, se;
  logic [15:0] tv_c, tu_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_radius <= 15'd256;
      sector_count <= 9'd36;
      stack_count <= 9'd18;
      center_x <= 16'sd0;
      center_y <= 16'sd0;
      center_z <= 16'sd0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RADIUS:   sphere_radius <= cfg_data[14:0];
        CFG_SECTORS:  sector_count <= cfg_data[8:0];
        CFG_STACKS:   stack_count <= cfg_data[8:0];
        CFG_CENTER_X: center_x <= cfg_data;
        CFG_CENTER_Y: center_y <= cfg_data;
        CFG_CENTER_Z: center_z <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (sector_count < 9'd3) begin
      sectors = 9'd3;
    end else if (sector_count > 9'(MAX_DIVISIONS)) begin
      sectors = 9'(MAX_DIVISIONS);
    end else begin
      sectors = sector_count;
    end
    if (stack_count < 9'd2) begin
      stacks = 9'd2;
    end else if (stack_count > 9'(MAX_DIVISIONS)) begin
      stacks = 9'(MAX_DIVISIONS);
    end else begin
      stacks = stack_count;
    end
    stk_clamped = (stack_index > stacks) ? stacks : stack_index;
    sec_clamped = (sector_index > sectors) ? sectors : sector_index;
  end

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in <= 1'b0;
    end else begin
      v_in <= start && !busy;
    end
    stk_in <= stk_clamped;
    sec_in <= sec_clamped;
  end

  uvs_div u_div_sector (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v_in),
    .idx       (sec_in),
    .divisor   ({1'b0, sectors}),
    .out_valid (sec_dv),
    .quot      (sec_quot)
  );

  uvs_div u_div_stack (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v_in),
    .idx       (stk_in),
    .divisor   ({stacks, 1'b0}),
    .out_valid (stk_dv),
    .quot      (stk_quot)
  );

  assign ph_sector = sec_quot[31:0];
  assign ph_stack = 32'h4000_0000 - stk_quot[31:0];
  assign tv_sum = {1'b0, sec_quot} + 34'd65536;
  assign tu_sum = {1'b0, stk_quot} + 34'd32768;
  assign tv_div = tv_sum[32:17];
  assign tu_div = tu_sum[31:16];

  uvs_cordic u_cordic_sector (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sec_dv),
    .phase     (ph_sector),
    .tag_in    (tv_div),
    .out_valid (ca_v),
    .cos_out   (ca),
    .sin_out   (sa),
    .tag_out   (tv_c)
  );

  uvs_cordic u_cordic_stack (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stk_dv),
    .phase     (ph_stack),
    .tag_in    (tu_div),
    .out_valid (ce_v),
    .cos_out   (ce),
    .sin_out   (se),
    .tag_out   (tu_c)
  );

  uvs_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ca_v && ce_v),
    .ce        (ce),
    .se        (se),
    .ca        (ca),
    .sa        (sa),
    .tu_in     (tu_c),
    .tv_in     (tv_c),
    .radius    (sphere_radius),
    .cx        (center_x),
    .cy        (center_y),
    .cz        (center_z),
    .out_valid (done),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .normal_x  (normal_x),
    .normal_y  (normal_y),
    .normal_z  (normal_z),
    .tex_u     (tex_u),
    .tex_v     (tex_v)
  );

endmodule
